// ===== hw/rtl/srxl2_frame_channel_decoder_macros.svh =====
// assertion macros shared by the frame channel decoder rtl
`ifndef SRXL2_FRAME_CHANNEL_DECODER_MACROS_SVH
`define SRXL2_FRAME_CHANNEL_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define SRXL2_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srxl2 decoder check failed");

// next-cycle implication, checked out of reset
`define SRXL2_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srxl2 decoder check failed");

`else

`define SRXL2_ASSERT_IMPL(label, ante, cons)
`define SRXL2_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/srxl2_fcd_pkg.sv =====
// shared constants, types and crc helper for the srxl2 frame channel decoder
package srxl2_fcd_pkg;

    localparam int DEF_BUFFER_BYTES = 80;

    localparam logic [7:0]  SYNC_BYTE     = 8'hA6;
    localparam logic [7:0]  TYPE_CONTROL  = 8'hCD;
    localparam logic [7:0]  SUBTYPE_CHAN  = 8'h00;
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam int          MIN_FRAME     = 5;
    localparam int          MASK_START    = 8;
    localparam int          PAYLOAD_START = 12;
    // shortest frame that carries at least one channel value
    localparam int          MIN_CHAN_FRAME = PAYLOAD_START + 4;

    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_CHANNEL = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;       // take the byte on the input channel
        logic load_status;  // load a frame status result
        logic walk_init;    // start the channel walk
        logic ch_inc;       // step to the next channel
        logic off_inc;      // step past one two-byte value
        logic ld_lo;        // capture the low value byte
        logic rd_hi;        // address the high value byte
        logic load_chan;    // load a channel value result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic frame_done;   // the offered byte completes a frame
        logic decode_go;    // frame carries channel values
        logic mask_bit;     // current channel is flagged
        logic chan_last;    // current value is the final result
        logic out_free;     // output register can take a result
    } status_t;

    // fold one byte into a crc-16, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/srxl2_fcd_ram.sv =====
// generic single-write, single-read ram with registered read data
module srxl2_fcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/srxl2_fcd_ctrl.sv =====
// controller state machine: byte intake, frame status and channel walk
module srxl2_fcd_ctrl
    import srxl2_fcd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t st,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_STATUS = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_RD_LO  = 3'd3;
    localparam logic [2:0] ST_RD_HI  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && st.frame_done)
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (st.out_free)
                begin
                    cmd.load_status = 1'b1;
                    cmd.walk_init   = 1'b1;
                    state_next      = st.decode_go ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (st.mask_bit)
                begin
                    state_next = ST_RD_LO;
                end
                else
                begin
                    cmd.ch_inc = 1'b1;
                end
            end
            ST_RD_LO:
            begin
                cmd.rd_hi  = 1'b1;
                cmd.ld_lo  = 1'b1;
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                cmd.rd_hi = 1'b1;
                if (st.out_free)
                begin
                    cmd.load_chan = 1'b1;
                    if (st.chan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.ch_inc  = 1'b1;
                        cmd.off_inc = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/srxl2_fcd_dp.sv =====
// datapath: frame buffer, running crc, header capture, channel walk, output register
module srxl2_fcd_dp
    import srxl2_fcd_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [31:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [8:0] LAST_POS = 9'(BUFFER_BYTES - 3);

    // write position and sticky link flag
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             detected_reg;

    // frame header, running crc and the two newest bytes
    logic [15:0] crc_reg;
    logic [7:0]  hist1_reg, hist2_reg;
    logic [7:0]  type_reg, len_reg, sub_reg;
    logic [31:0] mask_reg;

    // channel walk
    logic [4:0]  ch_reg;
    logic [8:0]  off_reg;
    logic [2:0]  lo_bits_reg;

    // output register
    logic        m_tvalid_reg;
    logic        kind_reg, ok_reg, link_reg, last_reg;
    logic [7:0]  ptype_reg;
    logic [4:0]  chan_reg;
    logic [10:0] value_reg;

    logic [8:0]  pos9, pos_inc9, rd_off9;
    logic        advance, overflow;
    logic        frame_done;
    logic [1:0]  mask_idx;
    logic        crc_ok;
    logic [31:0] mask_above;
    logic [7:0]  rd_data;
    logic [CNT_W-1:0] rd_addr;

    // position bookkeeping for the offered byte
    always_comb
    begin
        pos9       = 9'(pos_reg);
        pos_inc9   = pos9 + 9'd1;
        advance    = (pos_reg != '0) || (rx_byte == SYNC_BYTE);
        overflow   = pos_inc9 > LAST_POS;
        frame_done = advance && !overflow && (pos_inc9 >= 9'(MIN_FRAME))
                     && (pos_inc9 == {1'b0, len_reg});
        mask_idx   = 2'(pos9 - 9'(MASK_START));
        if (!advance)
        begin
            pos_next = pos_reg;
        end
        else if (overflow || frame_done)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = CNT_W'(pos_inc9);
        end
    end

    // decode decisions
    always_comb
    begin
        st.frame_done = frame_done;
        crc_ok        = crc_reg == {hist2_reg, hist1_reg};
        st.decode_go  = crc_ok && (type_reg == TYPE_CONTROL) && (sub_reg == SUBTYPE_CHAN)
                        && (len_reg >= 8'(MIN_CHAN_FRAME)) && (mask_reg != '0);
        mask_above    = mask_reg >> ch_reg;
        st.mask_bit   = mask_above[0];
        st.chan_last  = ((off_reg + 9'd6) > {1'b0, len_reg}) || (mask_above[31:1] == '0);
        st.out_free   = !m_tvalid_reg || m_tready;
        rd_off9       = cmd.rd_hi ? (off_reg + 9'd1) : off_reg;
        rd_addr       = rd_off9[CNT_W-1:0];
    end

    // frame buffer
    srxl2_fcd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .clk     (clk),
        .wr_en   (cmd.accept),
        .wr_addr (pos_reg),
        .wr_data (rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            detected_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pos_reg <= pos_next;
            end
            if (cmd.load_status && crc_ok)
            begin
                detected_reg <= 1'b1;
            end
            if (cmd.load_status || cmd.load_chan)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // crc delayed by two bytes so the trailing crc bytes stay out of it
    always_ff @(posedge clk)
    begin
        if (cmd.accept && advance)
        begin
            if (pos_reg == '0)
            begin
                crc_reg   <= '0;
                hist1_reg <= rx_byte;
            end
            else
            begin
                if (pos9 >= 9'd2)
                begin
                    crc_reg <= crc16_byte(crc_reg, hist2_reg);
                end
                hist2_reg <= hist1_reg;
                hist1_reg <= rx_byte;
            end
        end
    end

    // header field capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (pos9 == 9'd1)
            begin
                type_reg <= rx_byte;
            end
            if (pos9 == 9'd2)
            begin
                len_reg <= rx_byte;
            end
            if (pos9 == 9'd3)
            begin
                sub_reg <= rx_byte;
            end
            if ((pos9 >= 9'(MASK_START)) && (pos9 < 9'(MASK_START + 4)))
            begin
                mask_reg[8*mask_idx +: 8] <= rx_byte;
            end
        end
    end

    // channel walk counters and low byte
    always_ff @(posedge clk)
    begin
        if (cmd.walk_init)
        begin
            ch_reg  <= '0;
            off_reg <= 9'(PAYLOAD_START);
        end
        else
        begin
            if (cmd.ch_inc)
            begin
                ch_reg <= ch_reg + 5'd1;
            end
            if (cmd.off_inc)
            begin
                off_reg <= off_reg + 9'd2;
            end
        end
        if (cmd.ld_lo)
        begin
            lo_bits_reg <= rd_data[7:5];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_status)
        begin
            kind_reg  <= KIND_STATUS;
            ok_reg    <= crc_ok;
            ptype_reg <= type_reg;
            chan_reg  <= '0;
            value_reg <= '0;
            link_reg  <= detected_reg || crc_ok;
            last_reg  <= !st.decode_go;
        end
        else if (cmd.load_chan)
        begin
            kind_reg  <= KIND_CHANNEL;
            ok_reg    <= 1'b1;
            ptype_reg <= type_reg;
            chan_reg  <= ch_reg;
            value_reg <= {rd_data, lo_bits_reg};
            link_reg  <= detected_reg;
            last_reg  <= st.chan_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, link_reg, value_reg, chan_reg, ptype_reg, ok_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hw/rtl/srxl2_frame_channel_decoder.sv =====
// top level of the srxl2 frame channel decoder
//
// Input channel s_*: one received serial byte per request. Output channel m_*:
// result requests, a frame status for every completed frame, then one request
// per decoded channel value of a valid control frame; tlast marks the final
// result caused by one input byte.
// In idle the input is always ready, so it accepts a byte every cycle between
// frames. The byte that completes a frame starts a result run during which no
// byte is taken: first the status request, then a walk over the channel-mask
// bits up to the last flagged one or the end of the frame, where a skipped
// channel passes the scan state and each emitted value the scan, low-byte and
// high-byte states, set by the single read port of the frame buffer. The crc
// is folded in while bytes arrive.
// Reset clears the write position, the link flag and the output valid; the
// frame buffer needs no clearing since every read hits an entry of the
// current frame. While the receiver stalls, the output register holds its
// request and the walk waits on it.
module srxl2_frame_channel_decoder
    import srxl2_fcd_pkg::*;
#(
    parameter int BUFFER_BYTES = DEF_BUFFER_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] crc_ok, [8:1] packet_type, [13:9] channel_number,
                                   // [24:14] chan_position, [25] link_detected, [31:26] zero
    output logic        m_tuser,   // [0] result_kind
    output logic        m_tlast
);

`include "srxl2_frame_channel_decoder_macros.svh"

    cmd_t    cmd;
    status_t st;

    // controller
    srxl2_fcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // datapath
    srxl2_fcd_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // a result is loaded only when the output register is free
    `SRXL2_ASSERT_IMPL(a_load_free, cmd.load_status || cmd.load_chan, !m_tvalid || m_tready)
    // channel values come only from good frames on a detected link
    `SRXL2_ASSERT_IMPL(a_chan_good, m_tvalid && (m_tuser == KIND_CHANNEL), m_tdata[0] && m_tdata[25])
    // a completing byte blocks intake while its results are built
    `SRXL2_ASSERT_NEXT(a_done_block, s_tvalid && s_tready && st.frame_done, !s_tready)

endmodule
